[sv/rbe_pkg.sv]
package rbe_pkg;

  // widths of the fixed fields
  localparam int unsigned READING_W   = 16;
  localparam int unsigned LEVEL_W     = 2;
  localparam int unsigned LAST_LVL_W  = 3;
  localparam int unsigned REASON_W    = 3;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned THRESH_W    = 16;
  localparam int unsigned INTERVAL_W  = 24;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_IDX_W   = 2;

  // packed word widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam int unsigned ELAPSED_BITS_DEF = 24;

  // register reset values
  localparam logic [THRESH_W-1:0]   DELTA_RST     = 16'd50;
  localparam logic [INTERVAL_W-1:0] HEARTBEAT_RST = 24'd30000;
  localparam logic [INTERVAL_W-1:0] MIN_INT_RST   = 24'd5000;

  // emergency handling
  localparam logic [INTERVAL_W-1:0] EMERGENCY_FLOOR_MS = 24'd2000;
  localparam logic [LAST_LVL_W-1:0] EMERGENCY_LEVEL    = 3'd2;
  localparam logic [LAST_LVL_W-1:0] NO_LEVEL           = 3'd7;

  typedef enum logic [REASON_W-1:0] {
    RSN_RATE      = 3'd0,
    RSN_FIRST     = 3'd1,
    RSN_LEVEL     = 3'd2,
    RSN_HEARTBEAT = 3'd3,
    RSN_DELTA     = 3'd4,
    RSN_SAME      = 3'd5
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELTA     = 2'd0,
    CFG_HEARTBEAT = 2'd1,
    CFG_MIN_INT   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

endpackage

[sv/report_by_exception_filter.sv]
// Report-by-exception filter. Each input word is either a one millisecond tick
// (in_tuser = 0) or a sensor sample (in_tuser = 1, reading and alarm level in
// in_tdata). Ticks advance a saturating counter of time since the last send and
// give no output; every sample gives exactly one output word with the send
// decision, its reason and the running sent and dropped totals. The block
// takes one word per clock unless a sample waits for the output register to be
// taken: a word is registered in the input register, judged there against the
// filter state, and the verdict sits in the output register until taken; the
// state update for one item is visible to the very next one. Registers are
// written through the cfg port (index 0 delta threshold, 1 heartbeat,
// 2 minimum interval, others ignored); write them only while the block is idle.
module report_by_exception_filter #(
  parameter int unsigned ELAPSED_BITS = rbe_pkg::ELAPSED_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input words
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rbe_pkg::IN_TDATA_W-1:0]       in_tdata,  // reading[15:0], level[17:16]
  input  logic [0:0]                           in_tuser,  // op[0]
  // result words
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rbe_pkg::OUT_TDATA_W-1:0]      out_tdata, // reason[2:0], sent_total[34:3],
                                                          // dropped_total[66:35]
  output logic [0:0]                           out_tuser, // send[0]
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rbe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rbe_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // compare width covering both the counter and the interval registers
  localparam int unsigned CMP_W = (ELAPSED_BITS > rbe_pkg::INTERVAL_W) ?
                                  ELAPSED_BITS : rbe_pkg::INTERVAL_W;

  // config registers
  logic [rbe_pkg::THRESH_W-1:0]   delta_thr_r;
  logic [rbe_pkg::INTERVAL_W-1:0] heartbeat_r;
  logic [rbe_pkg::INTERVAL_W-1:0] min_int_r;

  // input stage
  logic                          s1_valid_r;
  logic                          s1_op_r;
  logic [rbe_pkg::READING_W-1:0] s1_reading_r;
  logic [rbe_pkg::LEVEL_W-1:0]   s1_level_r;

  // filter state
  logic [ELAPSED_BITS-1:0]         elapsed_r, elapsed_nxt;
  logic [rbe_pkg::READING_W-1:0]   last_value_r;
  logic                            have_sent_r;
  logic [rbe_pkg::LAST_LVL_W-1:0]  last_level_r, last_level_nxt;
  logic [rbe_pkg::COUNT_W-1:0]     sent_count_r, sent_count_nxt;
  logic [rbe_pkg::COUNT_W-1:0]     dropped_count_r, dropped_count_nxt;

  // output stage
  logic                            out_valid_r;
  logic                            out_send_r;
  rbe_pkg::reason_t                out_reason_r;
  logic [rbe_pkg::COUNT_W-1:0]     out_sent_r;
  logic [rbe_pkg::COUNT_W-1:0]     out_dropped_r;

  // judge path
  logic                            s1_is_sample;
  logic                            out_free;
  logic                            s1_fire;
  logic                            sample_fire;
  logic                            tick_fire;
  logic                            send;
  rbe_pkg::reason_t                reason;
  logic [rbe_pkg::LAST_LVL_W-1:0]  level_ext;
  logic [rbe_pkg::INTERVAL_W-1:0]  eff_int;
  logic [CMP_W-1:0]                elapsed_cmp;
  logic                            rate_hit;
  logic                            hb_hit;
  logic signed [rbe_pkg::READING_W:0] diff;
  logic [rbe_pkg::READING_W:0]     mag;
  logic                            delta_hit;

  // handshake
  assign s1_is_sample = (s1_op_r == rbe_pkg::OP_SAMPLE);
  assign out_free     = !out_valid_r || out_tready;
  assign s1_fire      = s1_valid_r && (!s1_is_sample || out_free);
  assign sample_fire  = s1_fire && s1_is_sample;
  assign tick_fire    = s1_fire && !s1_is_sample;
  assign in_tready    = !s1_valid_r || s1_fire;
  assign cfg_ready    = 1'b1;

  // send decision
  always_comb begin
    level_ext   = {1'b0, s1_level_r};
    elapsed_cmp = CMP_W'(elapsed_r);
    eff_int     = min_int_r;
    if ((level_ext == rbe_pkg::EMERGENCY_LEVEL) &&
        (last_level_r != rbe_pkg::EMERGENCY_LEVEL) &&
        (rbe_pkg::EMERGENCY_FLOOR_MS < min_int_r)) begin
      eff_int = rbe_pkg::EMERGENCY_FLOOR_MS;
    end
    rate_hit  = elapsed_cmp < CMP_W'(eff_int);
    hb_hit    = elapsed_cmp >= CMP_W'(heartbeat_r);
    diff      = $signed({s1_reading_r[rbe_pkg::READING_W-1], s1_reading_r}) -
                $signed({last_value_r[rbe_pkg::READING_W-1], last_value_r});
    mag       = diff[rbe_pkg::READING_W] ? (rbe_pkg::READING_W+1)'(-diff) :
                                           $unsigned(diff);
    delta_hit = mag >= {1'b0, delta_thr_r};

    send   = 1'b0;
    reason = rbe_pkg::RSN_SAME;
    if (!have_sent_r) begin
      send   = 1'b1;
      reason = rbe_pkg::RSN_FIRST;
    end else if (rate_hit) begin
      reason = rbe_pkg::RSN_RATE;
    end else if (level_ext != last_level_r) begin
      send   = 1'b1;
      reason = rbe_pkg::RSN_LEVEL;
    end else if (hb_hit) begin
      send   = 1'b1;
      reason = rbe_pkg::RSN_HEARTBEAT;
    end else if (delta_hit) begin
      send   = 1'b1;
      reason = rbe_pkg::RSN_DELTA;
    end
  end

  // next state
  always_comb begin
    elapsed_nxt       = elapsed_r;
    last_level_nxt    = last_level_r;
    sent_count_nxt    = sent_count_r;
    dropped_count_nxt = dropped_count_r;
    if (tick_fire && (elapsed_r != {ELAPSED_BITS{1'b1}})) begin
      elapsed_nxt = elapsed_r + ELAPSED_BITS'(1);
    end
    if (sample_fire) begin
      if (send) begin
        elapsed_nxt    = '0;
        last_level_nxt = level_ext;
        sent_count_nxt = sent_count_r + rbe_pkg::COUNT_W'(1);
      end else if (reason == rbe_pkg::RSN_RATE) begin
        dropped_count_nxt = dropped_count_r + rbe_pkg::COUNT_W'(1);
      end
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_thr_r <= rbe_pkg::DELTA_RST;
      heartbeat_r <= rbe_pkg::HEARTBEAT_RST;
      min_int_r   <= rbe_pkg::MIN_INT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbe_pkg::CFG_DELTA:     delta_thr_r <= cfg_data[rbe_pkg::THRESH_W-1:0];
        rbe_pkg::CFG_HEARTBEAT: heartbeat_r <= cfg_data;
        rbe_pkg::CFG_MIN_INT:   min_int_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r      <= in_tuser[0];
      s1_reading_r <= in_tdata[rbe_pkg::READING_W-1:0];
      s1_level_r   <= in_tdata[rbe_pkg::READING_W +: rbe_pkg::LEVEL_W];
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r       <= '0;
      have_sent_r     <= 1'b0;
      last_level_r    <= rbe_pkg::NO_LEVEL;
      sent_count_r    <= '0;
      dropped_count_r <= '0;
    end else begin
      elapsed_r       <= elapsed_nxt;
      last_level_r    <= last_level_nxt;
      sent_count_r    <= sent_count_nxt;
      dropped_count_r <= dropped_count_nxt;
      if (sample_fire && send) begin
        have_sent_r <= 1'b1;
      end
    end
  end

  // last sent value, no reset needed
  always_ff @(posedge clk) begin
    if (sample_fire && send) begin
      last_value_r <= s1_reading_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= sample_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_fire) begin
      out_send_r    <= send;
      out_reason_r  <= reason;
      out_sent_r    <= sent_count_nxt;
      out_dropped_r <= dropped_count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_send_r;
  assign out_tdata  = rbe_pkg::OUT_TDATA_W'({out_dropped_r, out_sent_r, out_reason_r});

`ifndef SYNTH
  // a sent word never carries a no-send reason
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_reason_r != rbe_pkg::RSN_RATE && out_reason_r != rbe_pkg::RSN_SAME)
    else $error("send flagged with a no-send reason");

  // a held word never carries a send reason
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_reason_r == rbe_pkg::RSN_RATE || out_reason_r == rbe_pkg::RSN_SAME)
    else $error("drop flagged with a send reason");

  // nothing counted as sent before the first send
  assert property (@(posedge clk) disable iff (!rst_n)
    !have_sent_r |-> sent_count_r == '0)
    else $error("sent count moved before first send");

  // a rate-limited sample bumps the dropped count by one
  assert property (@(posedge clk) disable iff (!rst_n)
    sample_fire && reason == rbe_pkg::RSN_RATE |=>
      dropped_count_r == $past(dropped_count_r) + rbe_pkg::COUNT_W'(1))
    else $error("dropped count not advanced");
`endif

endmodule

[tb/rbe_verdict_checker.sv]
module rbe_verdict_checker
  import rbe_pkg::*;
#(
  parameter int unsigned ELAPSED_BITS = ELAPSED_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // reading[15:0], level[17:16]
  input  logic [0:0]             in_tuser,   // op[0]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // reason[2:0], sent_total[34:3],
                                             // dropped_total[66:35]
  input  logic [0:0]             out_tuser,  // send[0]
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int unsigned            fail_count,
  output int unsigned            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SHOWN_FAILS = 10;

  typedef struct packed {
    logic               send;
    reason_t            why;
    logic [COUNT_W-1:0] sent;
    logic [COUNT_W-1:0] dropped;
  } verdict_t;

  // verdicts for samples taken in but not yet seen at the output
  verdict_t pending_verdicts[$];

  // register copies
  logic [THRESH_W-1:0]     delta_min;
  logic [INTERVAL_W-1:0]   beat_ms;
  logic [INTERVAL_W-1:0]   holdoff_ms;

  // filter state
  logic [ELAPSED_BITS-1:0] since_send_ms;
  logic [READING_W-1:0]    last_reading;
  logic                    sent_once;
  logic [LAST_LVL_W-1:0]   prev_level;
  logic [COUNT_W-1:0]      n_sent;
  logic [COUNT_W-1:0]      n_dropped;

  // decide one sample and commit it to the model state as it is taken in
  function automatic verdict_t judge_sample(input logic [READING_W-1:0] rd,
                                            input logic [LEVEL_W-1:0]   lvl);
    verdict_t              v;
    logic [INTERVAL_W-1:0] wait_ms;
    logic [LAST_LVL_W-1:0] lvl3;
    int                    diff;
    int unsigned           swing;
    lvl3 = {1'b0, lvl};
    v.send = 1'b0;
    v.why = RSN_SAME;
    if (!sent_once) begin
      v.why = RSN_FIRST;
      v.send = 1'b1;
    end else begin
      // escalation into emergency cuts the hold-off short
      wait_ms = holdoff_ms;
      if (lvl3 == EMERGENCY_LEVEL && prev_level != EMERGENCY_LEVEL &&
          EMERGENCY_FLOOR_MS < holdoff_ms)
        wait_ms = EMERGENCY_FLOOR_MS;
      diff = int'(signed'(rd)) - int'(signed'(last_reading));
      swing = (diff < 0) ? -diff : diff;
      if (since_send_ms < wait_ms) begin
        v.why = RSN_RATE;
        n_dropped++;
      end else if (lvl3 != prev_level) begin
        v.why = RSN_LEVEL;
        v.send = 1'b1;
      end else if (since_send_ms >= beat_ms) begin
        v.why = RSN_HEARTBEAT;
        v.send = 1'b1;
      end else if (swing >= delta_min) begin
        v.why = RSN_DELTA;
        v.send = 1'b1;
      end
    end
    if (v.send) begin
      last_reading = rd;
      since_send_ms = '0;
      prev_level = lvl3;
      sent_once = 1'b1;
      n_sent++;
    end
    v.sent = n_sent;
    v.dropped = n_dropped;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t             want;
    logic                 got_send;
    logic [REASON_W-1:0]  got_why;
    logic [COUNT_W-1:0]   got_sent;
    logic [COUNT_W-1:0]   got_dropped;
    if (!rst_n) begin
      delta_min = DELTA_RST;
      beat_ms = HEARTBEAT_RST;
      holdoff_ms = MIN_INT_RST;
      since_send_ms = '0;
      last_reading = '0;
      sent_once = 1'b0;
      prev_level = NO_LEVEL;
      n_sent = '0;
      n_dropped = '0;
      fail_count = 0;
      pending_verdicts.delete();
    end else begin
      // register writes are to come only while idle; the checker does not enforce it
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DELTA:     delta_min = cfg_data[THRESH_W-1:0];
          CFG_HEARTBEAT: beat_ms = cfg_data[INTERVAL_W-1:0];
          CFG_MIN_INT:   holdoff_ms = cfg_data[INTERVAL_W-1:0];
          default: ;
        endcase
      end

      // result word against the oldest verdict
      if (out_tvalid && out_tready) begin
        got_send = out_tuser[0];
        got_why = out_tdata[REASON_W-1:0];
        got_sent = out_tdata[REASON_W +: COUNT_W];
        got_dropped = out_tdata[REASON_W+COUNT_W +: COUNT_W];
        if (pending_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_FAILS)
            $display("%0t: result word with no sample behind it: send %0b reason %0d",
                     $realtime, got_send, got_why);
        end else begin
          want = pending_verdicts.pop_front();
          if (got_send !== want.send || got_why !== want.why ||
              got_sent !== want.sent || got_dropped !== want.dropped) begin
            fail_count++;
            if (fail_count <= SHOWN_FAILS)
              $display("%0t: expected send %0b reason %0d sent %0d dropped %0d",
                       $realtime, want.send, want.why, want.sent, want.dropped,
                       " / got send %0b reason %0d sent %0d dropped %0d",
                       got_send, got_why, got_sent, got_dropped);
          end
        end
      end

      // samples are judged, ticks advance the saturating timer
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == OP_SAMPLE)
          pending_verdicts.push_back(judge_sample(in_tdata[READING_W-1:0],
                                                  in_tdata[READING_W +: LEVEL_W]));
        else if (since_send_ms != '1)
          since_send_ms++;
      end
    end
    pending = pending_verdicts.size();
  end

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rbe_pkg::*;

  // index with no register behind it, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 30;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // reading[15:0], level[17:16]
  logic [0:0]             in_tuser;   // op[0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // reason[2:0], sent_total[34:3], dropped_total[66:35]
  logic [0:0]             out_tuser;  // send[0]
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int unsigned            fail_count;
  int unsigned            pending;

  int                     burst_left;
  logic [READING_W-1:0]   base_rd;
  logic [LEVEL_W-1:0]     cur_lvl;
  logic [THRESH_W-1:0]    cur_thresh;
  rx_mode_t               rx_mode = RX_OPEN;
  int unsigned            rx_left = 0;

  report_by_exception_filter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rbe_verdict_checker u_verdicts (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side stalls on its own pattern, picking a new one each time its random run ends
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
      default:   out_tready <= (rx_left[2:0] != 3'd0);
    endcase
  end

  // hard stop
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // one input word, sent in bursts with random gaps between them
  task automatic push_word(input op_t op, input logic [READING_W-1:0] rd,
                           input logic [LEVEL_W-1:0] lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= IN_TDATA_W'({lvl, rd});
    do @(posedge clk); while (!in_tready);
  endtask

  // ticks carry junk in the unused fields
  task automatic tick_run(input int n);
    repeat (n)
      push_word(OP_TICK, READING_W'($urandom_range(0, 65535)),
                LEVEL_W'($urandom_range(0, 3)));
  endtask

  // hold the sender until every verdict is back and the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all registers, plus junk to the spare index
  task automatic load_regs(input logic [THRESH_W-1:0] thresh,
                           input logic [INTERVAL_W-1:0] beat,
                           input logic [INTERVAL_W-1:0] hold);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    idx = '{CFG_SPARE, CFG_DELTA, CFG_HEARTBEAT, CFG_MIN_INT};
    val = '{CFG_DATA_W'($urandom), CFG_DATA_W'(thresh), beat, hold};
    cur_thresh = thresh;
    cfg_valid <= 1'b1;
    foreach (idx[i]) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [INTERVAL_W-1:0] pick_interval(input int unsigned top_small);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return INTERVAL_W'($urandom);
      default: return INTERVAL_W'($urandom_range(1, top_small));
    endcase
  endfunction

  function automatic logic [THRESH_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return THRESH_W'($urandom);
      default: return THRESH_W'($urandom_range(1, 300));
    endcase
  endfunction

  // mostly a drift around the threshold, now and then a jump anywhere
  function automatic logic [READING_W-1:0] next_reading();
    int span;
    if ($urandom_range(0, 4) == 0)
      return READING_W'($urandom);
    span = (cur_thresh > 16'd2000) ? 2000 : int'(cur_thresh) + 4;
    return base_rd + READING_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  initial begin
    int words;
    int run;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    burst_left = 0;
    base_rd = '0;
    cur_lvl = '0;
    cur_thresh = DELTA_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: first sample always out, the next one held off
    push_word(OP_SAMPLE, 16'h8000, 2'd0);
    push_word(OP_SAMPLE, 16'h0000, 2'd3);
    push_word(OP_TICK, 16'hFFFF, 2'd3);
    push_word(OP_TICK, 16'h0000, 2'd0);

    // no hold-off, full-scale threshold, heartbeat out of reach
    settle();
    load_regs('1, '1, '0);
    push_word(OP_SAMPLE, 16'h7FFF, 2'd0);
    push_word(OP_SAMPLE, 16'h7FFE, 2'd0);
    push_word(OP_SAMPLE, 16'h8000, 2'd0);
    push_word(OP_SAMPLE, 16'h8000, 2'd1);

    // zero heartbeat sends whatever passes the hold-off
    settle();
    load_regs('1, '0, '0);
    push_word(OP_SAMPLE, 16'h8001, 2'd1);

    // zero threshold sends even an unchanged reading
    settle();
    load_regs('0, '1, '0);
    push_word(OP_SAMPLE, 16'h8001, 2'd1);

    // emergency escalation only waits the shortened interval, one tick short
    // of it still drops
    settle();
    load_regs('1, '1, 24'd2500);
    push_word(OP_SAMPLE, 16'h0000, 2'd1);
    tick_run(1999);
    push_word(OP_SAMPLE, 16'h0005, 2'd2);
    tick_run(1);
    push_word(OP_SAMPLE, 16'h0005, 2'd2);
    push_word(OP_SAMPLE, 16'h0005, 2'd1);

    // hold-off at its top drops everything
    settle();
    load_regs(DELTA_RST, HEARTBEAT_RST, '1);
    push_word(OP_SAMPLE, 16'h0064, 2'd0);
    push_word(OP_SAMPLE, 16'hFF9C, 2'd3);

    // random phases, each with its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      load_regs(pick_threshold(), pick_interval(80), pick_interval(30));
      words = 0;
      while (words < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 4) < 2) begin
          run = $urandom_range(1, 12);
          tick_run(run);
          words += run;
        end else begin
          if ($urandom_range(0, 4) == 0)
            cur_lvl = LEVEL_W'($urandom_range(0, 3));
          base_rd = next_reading();
          push_word(OP_SAMPLE, base_rd, cur_lvl);
          words++;
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
